/* hdl/fgn_pkg.sv */
// ----------------------------------------------------------------------------
// Fractal gradient noise package
// Shared constants, codes and types for the fractal gradient noise block.
// ----------------------------------------------------------------------------
`default_nettype none

package fgn_pkg;

  // Default sizes of the gradient table and of the octave loop.
  localparam int TABLE_SIZE_DEF  = 1024;
  localparam int MAX_OCTAVES_DEF = 8;

  // Fixed-point one in Q.16 and the corner hash multipliers.
  localparam int ONE_Q16  = 65536;
  localparam int HASH_ROW = 41;
  localparam int HASH_COL = 43;

  // Depth of the command queue between front and back; a power of two.
  localparam int QUEUE_DEPTH = 2;

  // Width of the octave accumulator before saturation.
  localparam int ACC_W = 40;

  // Input action codes.
  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] REG_OCTAVE_COUNT   = 2'd0;
  localparam logic [1:0] REG_BASE_FREQUENCY = 2'd1;
  localparam logic [1:0] REG_LACUNARITY     = 2'd2;
  localparam logic [1:0] REG_OCTAVE_GAIN    = 2'd3;

  // Configuration reset values.
  localparam logic [3:0]  OCTAVE_COUNT_RST   = 4'd4;
  localparam logic [23:0] BASE_FREQUENCY_RST = 24'd65536;
  localparam logic [23:0] LACUNARITY_RST     = 24'd131072;
  localparam logic [16:0] OCTAVE_GAIN_RST    = 17'd32768;

  typedef enum logic {
    CMD_LOAD,
    CMD_SAMPLE
  } fgn_kind_t;

  // One queued command. A load carries {grad_y, grad_x} in arg_a and the
  // entry index in arg_b; a sample carries x in arg_a and y in arg_b.
  typedef struct packed {
    fgn_kind_t   kind;
    logic [31:0] arg_a;
    logic [31:0] arg_b;
  } fgn_cmd_t;

  typedef struct packed {
    logic [3:0]  octave_count;
    logic [23:0] base_frequency;
    logic [23:0] lacunarity;
    logic [16:0] octave_gain;
  } fgn_cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_READ,
    ST_DOT,
    ST_BLEND_U,
    ST_BLEND_V,
    ST_ACCUM,
    ST_DONE
  } fgn_state_t;

endpackage

`default_nettype wire

/* hdl/fractal_gradient_noise.sv */
// A load passes the front-end hold register and the queue and is written to
// the table when the engine takes it from the queue. A sample runs the octave
// loop for the clamped octave count; each octave reads its four corners in
// turn through the single read port of the gradient table. The engine takes
// no new command while a sample runs; a load does not leave the idle state.
// Reset clears control and configuration; the table holds no reset value.
// ----------------------------------------------------------------------------
// Fractal gradient noise
// Fractal sum of 2D gradient noise over a loadable gradient table.
// ----------------------------------------------------------------------------
`default_nettype none

module fractal_gradient_noise #(
  parameter int TABLE_SIZE  = fgn_pkg::TABLE_SIZE_DEF,
  parameter int MAX_OCTAVES = fgn_pkg::MAX_OCTAVES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [23:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        action,
  input  wire logic [31:0] sample_x,
  input  wire logic [31:0] sample_y,
  input  wire logic [9:0]  entry_index,
  input  wire logic [15:0] grad_x,
  input  wire logic [15:0] grad_y,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      noise_value
);
  import fgn_pkg::*;

  fgn_cfg_t cfg;
  logic     q_push;
  fgn_cmd_t q_push_cmd;
  logic     q_full;
  logic     q_pop;
  logic     q_head_valid;
  fgn_cmd_t q_head_cmd;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.octave_count   <= OCTAVE_COUNT_RST;
      cfg.base_frequency <= BASE_FREQUENCY_RST;
      cfg.lacunarity     <= LACUNARITY_RST;
      cfg.octave_gain    <= OCTAVE_GAIN_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_OCTAVE_COUNT:   cfg.octave_count   <= cfg_data[3:0];
        REG_BASE_FREQUENCY: cfg.base_frequency <= cfg_data;
        REG_LACUNARITY:     cfg.lacunarity     <= cfg_data;
        REG_OCTAVE_GAIN:    cfg.octave_gain    <= cfg_data[16:0];
        default: begin
        end
      endcase
    end
  end

  fgn_front #(
    .TABLE_SIZE(TABLE_SIZE)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .action     (action),
    .sample_x   (sample_x),
    .sample_y   (sample_y),
    .entry_index(entry_index),
    .grad_x     (grad_x),
    .grad_y     (grad_y),
    .push       (q_push),
    .push_cmd   (q_push_cmd),
    .q_full     (q_full)
  );

  fgn_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_cmd  (q_push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .head_valid(q_head_valid),
    .head_cmd  (q_head_cmd)
  );

  fgn_back #(
    .TABLE_SIZE (TABLE_SIZE),
    .MAX_OCTAVES(MAX_OCTAVES)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (q_head_valid),
    .head_cmd   (q_head_cmd),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .noise_value(noise_value)
  );

`ifndef SYNTHESIS
  // The engine only takes a command that the queue holds.
  a_pop_has_head: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_head_valid) else $error("queue popped while empty");

  // The front end never pushes into a full queue.
  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full) else $error("queue pushed while full");

  // No result is shown in the first cycle after reset.
  a_reset_quiet: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !out_valid) else $error("result right after reset");
`endif

endmodule

`default_nettype wire

/* hdl/fgn_front.sv */
// ----------------------------------------------------------------------------
// Fractal gradient noise front end
// Accepts input transactions, classifies them into commands and drops loads
// aimed beyond the table. Holds one command until the queue takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module fgn_front #(
  parameter int TABLE_SIZE = fgn_pkg::TABLE_SIZE_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              action,
  input  wire logic [31:0]       sample_x,
  input  wire logic [31:0]       sample_y,
  input  wire logic [9:0]        entry_index,
  input  wire logic [15:0]       grad_x,
  input  wire logic [15:0]       grad_y,
  output logic                   push,
  output fgn_pkg::fgn_cmd_t      push_cmd,
  input  wire logic              q_full
);
  import fgn_pkg::*;

  logic     hold_valid;
  fgn_cmd_t hold_cmd;
  fgn_cmd_t cmd_next;
  logic     accept;
  logic     keep;

  // The held command moves on whenever the queue has room.
  assign push     = hold_valid && !q_full;
  assign push_cmd = hold_cmd;
  assign in_stall = hold_valid && q_full;
  assign accept   = in_valid && !in_stall;

  // Classify the transaction; loads beyond the table are dropped.
  always_comb begin
    if (action == ACT_SAMPLE) begin
      cmd_next.kind  = CMD_SAMPLE;
      cmd_next.arg_a = sample_x;
      cmd_next.arg_b = sample_y;
      keep           = 1'b1;
    end else begin
      cmd_next.kind  = CMD_LOAD;
      cmd_next.arg_a = {grad_y, grad_x};
      cmd_next.arg_b = 32'(entry_index);
      keep           = 32'(entry_index) < 32'(TABLE_SIZE);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= keep;
    end else if (push) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_cmd <= cmd_next;
    end
  end

endmodule

`default_nettype wire

/* hdl/fgn_queue.sv */
// ----------------------------------------------------------------------------
// Fractal gradient noise command queue
// Short first-in first-out queue that decouples the front end from the
// octave engine.
// ----------------------------------------------------------------------------
`default_nettype none

module fgn_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire fgn_pkg::fgn_cmd_t push_cmd,
  output logic                   full,
  input  wire logic              pop,
  output logic                   head_valid,
  output fgn_pkg::fgn_cmd_t      head_cmd
);
  import fgn_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  fgn_cmd_t        slots [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign full       = count == CW'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head_cmd   = slots[rd_ptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

/* hdl/fgn_back.sv */
// ----------------------------------------------------------------------------
// Fractal gradient noise octave engine
// Owns the gradient table, runs the octave loop for sample commands and
// holds the finished result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module fgn_back #(
  parameter int TABLE_SIZE  = fgn_pkg::TABLE_SIZE_DEF,
  parameter int MAX_OCTAVES = fgn_pkg::MAX_OCTAVES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire fgn_pkg::fgn_cfg_t cfg,
  input  wire logic              head_valid,
  input  wire fgn_pkg::fgn_cmd_t head_cmd,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [31:0]            noise_value
);
  import fgn_pkg::*;

  localparam int IW = $clog2(TABLE_SIZE);
  localparam int OW = $clog2(MAX_OCTAVES + 1);

  // Linear blend a + fade * (b - a), floored.
  function automatic logic signed [21:0] lerp(input logic signed [21:0] a,
                                              input logic signed [21:0] b,
                                              input logic [16:0] t);
    logic signed [22:0] diff;
    logic signed [40:0] prod;
    logic signed [24:0] step;
    diff = 23'(b) - 23'(a);
    prod = diff * $signed({1'b0, t});
    step = prod[40:16];
    return a + 22'(step);
  endfunction

  fgn_state_t state;
  fgn_state_t state_next;

  logic [31:0]        mem [TABLE_SIZE];
  logic [31:0]        rdata;
  logic [IW-1:0]      raddr;

  logic signed [31:0] px;
  logic signed [31:0] py;
  logic [23:0]        freq;
  logic [16:0]        amp;
  logic [16:0]        gain;
  logic [OW-1:0]      oct;
  logic [OW-1:0]      oct_cnt;
  logic signed [ACC_W-1:0] acc;

  logic [IW-1:0]      xc;
  logic [IW-1:0]      yc;
  logic [15:0]        u;
  logic [15:0]        v;
  logic [1:0]         rc;
  logic [1:0]         rd_corner;
  logic               rd_valid;
  logic [15:0]        t2u;
  logic [15:0]        t2v;
  logic [16:0]        fu;
  logic [16:0]        fv;
  logic signed [18:0] dots [4];
  logic signed [21:0] bottom;
  logic signed [21:0] top;
  logic signed [21:0] noise;

  logic               start;
  logic               mem_we;
  logic               out_free;
  logic               out_load;
  logic [OW-1:0]      n_sat;
  logic [16:0]        gain_sat;

  logic signed [56:0] prod_x;
  logic signed [56:0] prod_y;
  logic [IW-1:0]      row;
  logic [IW-1:0]      col;
  logic signed [15:0] gx;
  logic signed [15:0] gy;
  logic signed [16:0] dx;
  logic signed [16:0] dy;
  logic signed [33:0] dot_sum;
  logic [31:0]        sq_u;
  logic [31:0]        sq_v;
  logic [17:0]        w_u;
  logic [17:0]        w_v;
  logic [33:0]        cube_u;
  logic [33:0]        cube_v;
  logic signed [39:0] wprod;
  logic signed [23:0] term;
  logic [47:0]        fprod;
  logic [23:0]        freq_next;
  logic [33:0]        aprod;
  logic [31:0]        sat_value;

  // Clamped octave count and gain for a new sample.
  assign n_sat    = (32'(cfg.octave_count) > 32'(MAX_OCTAVES)) ? OW'(MAX_OCTAVES)
                                                               : OW'(cfg.octave_count);
  assign gain_sat = (cfg.octave_gain > 17'(ONE_Q16)) ? 17'(ONE_Q16) : cfg.octave_gain;

  // Scaled point; bits from 32 up hold the cell, bits 31:16 the fraction.
  assign prod_x = px * $signed({1'b0, freq});
  assign prod_y = py * $signed({1'b0, freq});

  // Corner hash; low bit of the corner code steps x, high bit steps y.
  assign row   = xc + IW'(rc[0]);
  assign col   = yc + IW'(rc[1]);
  assign raddr = row * IW'(HASH_ROW) + col * IW'(HASH_COL);

  // Dot product of the gradient just read with its corner offset.
  assign gx      = rdata[15:0];
  assign gy      = rdata[31:16];
  assign dx      = {rd_corner[0], u};
  assign dy      = {rd_corner[1], v};
  assign dot_sum = gx * dx + gy * dy;

  // Fade curve in two steps: square, then times (3 - 2t).
  assign sq_u   = u * u;
  assign sq_v   = v * v;
  assign w_u    = 18'(3 * ONE_Q16) - {1'b0, u, 1'b0};
  assign w_v    = 18'(3 * ONE_Q16) - {1'b0, v, 1'b0};
  assign cube_u = t2u * w_u;
  assign cube_v = t2v * w_v;

  // Amplitude weighting and the per-octave frequency and amplitude steps.
  assign wprod     = $signed({1'b0, amp}) * noise;
  assign term      = wprod[39:16];
  assign fprod     = freq * cfg.lacunarity;
  assign freq_next = (|fprod[47:40]) ? 24'hFFFFFF : fprod[39:16];
  assign aprod     = amp * gain;

  // Saturation of the accumulated sum to 32 bits.
  always_comb begin
    if (acc > ACC_W'(64'sh7FFFFFFF)) begin
      sat_value = 32'h7FFFFFFF;
    end else if (acc < -ACC_W'(64'sh80000000)) begin
      sat_value = 32'h80000000;
    end else begin
      sat_value = acc[31:0];
    end
  end

  // Control outputs of the sequencer.
  always_comb begin
    out_free = !out_valid || !out_stall;
    pop      = (state == ST_IDLE) && head_valid;
    start    = pop && (head_cmd.kind == CMD_SAMPLE);
    mem_we   = pop && (head_cmd.kind == CMD_LOAD);
    out_load = (state == ST_DONE) && out_free;
  end

  // Next state of the sequencer.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = (n_sat == '0) ? ST_DONE : ST_SCALE;
        end
      end
      ST_SCALE:   state_next = ST_READ;
      ST_READ: begin
        if (rc == 2'd3) begin
          state_next = ST_DOT;
        end
      end
      ST_DOT:     state_next = ST_BLEND_U;
      ST_BLEND_U: state_next = ST_BLEND_V;
      ST_BLEND_V: state_next = ST_ACCUM;
      ST_ACCUM: begin
        state_next = ((oct + OW'(1)) == oct_cnt) ? ST_DONE : ST_SCALE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:    state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      rd_valid <= 1'b0;
    end else begin
      state    <= state_next;
      rd_valid <= (state == ST_READ);
    end
  end

  // Gradient table: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[head_cmd.arg_b[IW-1:0]] <= head_cmd.arg_a;
    end
    rdata <= mem[raddr];
  end

  // Octave datapath.
  always_ff @(posedge clk) begin
    rd_corner <= rc;
    if (rd_valid) begin
      dots[rd_corner] <= dot_sum[33:15];
    end
    case (state)
      ST_IDLE: begin
        if (start) begin
          px      <= head_cmd.arg_a;
          py      <= head_cmd.arg_b;
          freq    <= cfg.base_frequency;
          amp     <= 17'(ONE_Q16);
          gain    <= gain_sat;
          oct     <= '0;
          oct_cnt <= n_sat;
          acc     <= '0;
        end
      end
      ST_SCALE: begin
        xc <= prod_x[32+IW-1:32];
        yc <= prod_y[32+IW-1:32];
        u  <= prod_x[31:16];
        v  <= prod_y[31:16];
        rc <= 2'd0;
      end
      ST_READ: begin
        rc <= rc + 2'd1;
        if (rc == 2'd0) begin
          t2u <= sq_u[31:16];
          t2v <= sq_v[31:16];
        end
        if (rc == 2'd1) begin
          fu <= cube_u[32:16];
          fv <= cube_v[32:16];
        end
      end
      ST_BLEND_U: begin
        bottom <= lerp(22'(dots[0]), 22'(dots[1]), fu);
        top    <= lerp(22'(dots[2]), 22'(dots[3]), fu);
      end
      ST_BLEND_V: begin
        noise <= lerp(bottom, top, fv);
      end
      ST_ACCUM: begin
        acc  <= acc + ACC_W'(term);
        freq <= freq_next;
        amp  <= aprod[32:16];
        oct  <= oct + OW'(1);
      end
      default: begin
      end
    endcase
  end

  // Output register; the engine moves on while a result waits here.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      noise_value <= sat_value;
    end
  end

endmodule

`default_nettype wire
